// ===== sv/top_k_correlation_tracker_unit_defines.svh =====
// assertion macros for the top-k correlation tracker
`ifndef TOP_K_CORRELATION_TRACKER_UNIT_DEFINES_SVH
`define TOP_K_CORRELATION_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TKCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TKCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tkct_pkg.sv =====
// shared types and constants of the top-k correlation tracker
package tkct_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSCAN,
    ST_RSCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef logic signed [15:0] score_t;
  typedef logic [15:0]        tag_t;
  typedef logic [4:0]         kcfg_t;
  typedef logic [16:0]        abs_t;

  localparam kcfg_t  K_RESET      = 5'd16;
  localparam score_t THR_NOT_FULL = 16'sh8000;

  function automatic abs_t abs_score(input score_t s);
    logic signed [16:0] sx;
    sx = {s[15], s};
    abs_score = (sx < 0) ? abs_t'(-sx) : abs_t'(sx);
  endfunction

endpackage

// ===== sv/tkct_in_if.sv =====
// request channel of the top-k correlation tracker
interface tkct_in_if;
  import tkct_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  score_t      score;
  tag_t        tag;

  modport source (output valid, output req_type, output score, output tag, input ready);
  modport sink   (input valid, input req_type, input score, input tag, output ready);
endinterface

// ===== sv/tkct_out_if.sv =====
// result channel of the top-k correlation tracker
interface tkct_out_if;
  import tkct_pkg::*;

  logic        valid;
  logic        ready;
  score_t      entry_score;
  tag_t        entry_tag;
  logic        last;
  logic        list_full;
  score_t      threshold;
  logic [4:0]  held_count;

  modport source (output valid, output entry_score, output entry_tag, output last,
                  output list_full, output threshold, output held_count, input ready);
  modport sink   (input valid, input entry_score, input entry_tag, input last,
                  input list_full, input threshold, input held_count, output ready);
endinterface

// ===== sv/top_k_correlation_tracker_unit.sv =====
// top-k correlation tracker: candidate store, min scan and sorted readout
//
// Keeps the best k_in_use scored candidates in a small memory with one read
// port and walks it entry by entry. A request is taken only in idle.
// An insert that appends or is rejected, and a clear, give their result
// through the done state; an insert that replaces the minimum first
// rescans the store for the new minimum; a readout runs one full pass
// over the store per emitted entry. The memory's one read port sets this
// pace. A finished result waits in the output register while the next
// request is accepted.
`include "top_k_correlation_tracker_unit_defines.svh"

module top_k_correlation_tracker_unit #(
  parameter int MAX_K     = 16,
  parameter int TAG_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  tkct_pkg::kcfg_t cfg_wdata,
  tkct_in_if.sink        in_ch,
  tkct_out_if.source     out_ch
);
  import tkct_pkg::*;

  localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW = $clog2(MAX_K + 1);
  localparam int EW = (CW > 5) ? CW : 5;

  // candidate store
  score_t               score_mem [MAX_K];
  logic [TAG_WIDTH-1:0] tag_mem   [MAX_K];
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  score_t               rd_s_q;
  logic [TAG_WIDTH-1:0] rd_t_q;

  state_t               state_r, state_nxt;
  kcfg_t                k_r, k_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  score_t               min_r, min_nxt;
  logic [IW-1:0]        min_idx_r, min_idx_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic [CW-1:0]        emit_r, emit_nxt;
  abs_t                 prev_abs_r, prev_abs_nxt;
  logic [IW-1:0]        prev_idx_r, prev_idx_nxt;
  score_t               best_s_r, best_s_nxt;
  logic [TAG_WIDTH-1:0] best_t_r, best_t_nxt;
  abs_t                 best_abs_r, best_abs_nxt;
  logic [IW-1:0]        best_idx_r, best_idx_nxt;
  logic                 best_vld_r, best_vld_nxt;

  logic                 out_vld_r, out_vld_nxt;
  score_t               out_s_r, out_s_nxt;
  tag_t                 out_t_r, out_t_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_full_r, out_full_nxt;
  score_t               out_thr_r, out_thr_nxt;
  logic [4:0]           out_cnt_r, out_cnt_nxt;

  logic [EW-1:0]        k_ext, effk;
  logic                 full_w;
  score_t               thr_w;
  logic                 accept;
  logic                 slot_free;
  logic                 scan_done;
  logic [CW-1:0]        scan_m1;
  logic [IW-1:0]        scan_idx;
  abs_t                 rd_abs;
  logic                 eligible;
  logic                 take_r;
  logic                 take_m;
  logic                 last_w;

  // status and scan helpers
  always_comb begin
    k_ext     = EW'(k_r);
    if (k_r == '0) begin
      effk = EW'(1);
    end else if (k_ext > EW'(MAX_K)) begin
      effk = EW'(MAX_K);
    end else begin
      effk = k_ext;
    end
    full_w    = EW'(count_r) >= effk;
    thr_w     = (full_w && (count_r != '0)) ? min_r : THR_NOT_FULL;
    accept    = in_ch.valid && in_ch.ready;
    slot_free = !out_vld_r || out_ch.ready;
    scan_done = scan_r == count_r;
    scan_m1   = scan_r - CW'(1);
    scan_idx  = scan_m1[IW-1:0];
    rd_abs    = abs_score(rd_s_q);
    eligible  = (emit_r == '0) || (rd_abs < prev_abs_r) ||
                ((rd_abs == prev_abs_r) && (scan_idx > prev_idx_r));
    take_r    = eligible && (!best_vld_r || (rd_abs > best_abs_r));
    take_m    = (scan_idx == '0) || (rd_s_q < min_r);
    last_w    = (emit_r + CW'(1)) == count_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.req_type)
            REQ_INSERT: begin
              if (full_w && (in_ch.score > min_r)) begin
                state_nxt = ST_MSCAN;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            REQ_READ: begin
              if (count_r != '0) begin
                state_nxt = ST_RSCAN;
              end
            end
            REQ_CLEAR: begin
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MSCAN: begin
        if (scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RSCAN: begin
        if (scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = last_w ? ST_IDLE : ST_RSCAN;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    k_nxt        = cfg_we ? cfg_wdata : k_r;
    count_nxt    = count_r;
    min_nxt      = min_r;
    min_idx_nxt  = min_idx_r;
    scan_nxt     = scan_r;
    emit_nxt     = emit_r;
    prev_abs_nxt = prev_abs_r;
    prev_idx_nxt = prev_idx_r;
    best_s_nxt   = best_s_r;
    best_t_nxt   = best_t_r;
    best_abs_nxt = best_abs_r;
    best_idx_nxt = best_idx_r;
    best_vld_nxt = best_vld_r;
    out_s_nxt    = out_s_r;
    out_t_nxt    = out_t_r;
    out_last_nxt = out_last_r;
    out_full_nxt = out_full_r;
    out_thr_nxt  = out_thr_r;
    out_cnt_nxt  = out_cnt_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    mem_we       = 1'b0;
    mem_waddr    = min_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          scan_nxt     = '0;
          emit_nxt     = '0;
          best_vld_nxt = 1'b0;
          case (in_ch.req_type)
            REQ_INSERT: begin
              if (!full_w) begin
                mem_we    = 1'b1;
                mem_waddr = count_r[IW-1:0];
                count_nxt = count_r + CW'(1);
                if ((count_r == '0) || (in_ch.score < min_r)) begin
                  min_nxt     = in_ch.score;
                  min_idx_nxt = count_r[IW-1:0];
                end
              end else if (in_ch.score > min_r) begin
                mem_we = 1'b1;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
        end
      end
      ST_MSCAN: begin
        if ((scan_r != '0) && take_m) begin
          min_nxt     = rd_s_q;
          min_idx_nxt = scan_idx;
        end
        if (!scan_done) begin
          scan_nxt = scan_r + CW'(1);
        end
      end
      ST_RSCAN: begin
        if ((scan_r != '0) && take_r) begin
          best_s_nxt   = rd_s_q;
          best_t_nxt   = rd_t_q;
          best_abs_nxt = rd_abs;
          best_idx_nxt = scan_idx;
          best_vld_nxt = 1'b1;
        end
        if (!scan_done) begin
          scan_nxt = scan_r + CW'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_s_nxt    = best_s_r;
          out_t_nxt    = tag_t'(best_t_r);
          out_last_nxt = last_w;
          out_full_nxt = full_w;
          out_thr_nxt  = thr_w;
          out_cnt_nxt  = 5'(count_r);
          prev_abs_nxt = best_abs_r;
          prev_idx_nxt = best_idx_r;
          emit_nxt     = emit_r + CW'(1);
          scan_nxt     = '0;
          best_vld_nxt = 1'b0;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_s_nxt    = '0;
          out_t_nxt    = '0;
          out_last_nxt = 1'b1;
          out_full_nxt = full_w;
          out_thr_nxt  = thr_w;
          out_cnt_nxt  = 5'(count_r);
        end
      end
      default: begin
        out_vld_nxt = out_vld_r && !out_ch.ready;
      end
    endcase
  end

  // port outputs
  always_comb begin
    in_ch.ready        = state_r == ST_IDLE;
    out_ch.valid       = out_vld_r;
    out_ch.entry_score = out_s_r;
    out_ch.entry_tag   = out_t_r;
    out_ch.last        = out_last_r;
    out_ch.list_full   = out_full_r;
    out_ch.threshold   = out_thr_r;
    out_ch.held_count  = out_cnt_r;
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      score_mem[mem_waddr] <= in_ch.score;
      tag_mem[mem_waddr]   <= TAG_WIDTH'(in_ch.tag);
    end
    rd_s_q <= score_mem[scan_r[IW-1:0]];
    rd_t_q <= tag_mem[scan_r[IW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      k_r        <= K_RESET;
      count_r    <= '0;
      scan_r     <= '0;
      emit_r     <= '0;
      best_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      count_r    <= count_nxt;
      scan_r     <= scan_nxt;
      emit_r     <= emit_nxt;
      best_vld_r <= best_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    min_r      <= min_nxt;
    min_idx_r  <= min_idx_nxt;
    prev_abs_r <= prev_abs_nxt;
    prev_idx_r <= prev_idx_nxt;
    best_s_r   <= best_s_nxt;
    best_t_r   <= best_t_nxt;
    best_abs_r <= best_abs_nxt;
    best_idx_r <= best_idx_nxt;
    out_s_r    <= out_s_nxt;
    out_t_r    <= out_t_nxt;
    out_last_r <= out_last_nxt;
    out_full_r <= out_full_nxt;
    out_thr_r  <= out_thr_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  `TKCT_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CW'(MAX_K), "count above capacity")
  `TKCT_ASSERT_NXT(a_mscan_count, clk, rst_n, state_r == ST_MSCAN, $stable(count_r), "count moved in min scan")
  `TKCT_ASSERT_NXT(a_empty_read, clk, rst_n, accept && (in_ch.req_type == REQ_READ) && (count_r == '0), !$rose(out_vld_r), "result from empty readout")
  `TKCT_ASSERT_NXT(a_emit_load, clk, rst_n, (state_r == ST_EMIT) && slot_free, out_vld_r, "readout entry not loaded")

endmodule
